// ===== hdl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N sender.
// Used by gbn_front, gbn_back and go_back_n_sender_unit; no dependencies.
package gbn_pkg;

  localparam int WINDOW_MAX    = 8;
  localparam int PENDING_DEPTH = 16;

  localparam int DATA_W  = 16;
  localparam int WSIZE_W = 7;
  localparam int TOUT_W  = 16;

  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST   = 7'd8;
  localparam logic [TOUT_W-1:0]  TIMEOUT_TICKS_RST = 16'd20;

  // Input opcodes
  localparam logic [1:0] OP_MSG  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_NEW     = 2'd0;
  localparam logic [1:0] KIND_RETX    = 2'd1;
  localparam logic [1:0] KIND_QUEUED  = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  // Register indexes on the configuration port
  localparam logic REG_WINDOW_SIZE   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    CMD_MSG,
    CMD_ACK,
    CMD_TICK
  } gbn_cmd_t;

  typedef struct packed {
    gbn_cmd_t          cmd;
    logic [DATA_W-1:0] data;   // payload handle or acknowledgement number
  } gbn_entry_t;

  typedef struct packed {
    logic [WSIZE_W-1:0] window_size;
    logic [TOUT_W-1:0]  timeout_ticks;
  } gbn_cfg_t;

endpackage

// ===== hdl/gbn_front.sv =====
// Front end of the go-back-N sender: accepts input transactions, drops those
// with no effect, and queues the rest as commands. Depends on gbn_pkg.
module gbn_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [gbn_pkg::DATA_W-1:0] payload_handle,
  input  logic [gbn_pkg::DATA_W-1:0] ack_number,
  input  logic                      checksum_ok,
  output logic                      q_valid,
  output gbn_pkg::gbn_entry_t       q_head,
  input  logic                      q_pop
);

  localparam int QDEPTH = 2;

  gbn_pkg::gbn_entry_t q_mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;

  gbn_pkg::gbn_entry_t entry;
  logic                keep;
  logic                push;
  logic                pop;

  always_comb begin
    keep       = 1'b0;
    entry.cmd  = gbn_pkg::CMD_MSG;
    entry.data = payload_handle;
    unique case (opcode)
      gbn_pkg::OP_MSG: begin
        keep = 1'b1;
      end
      gbn_pkg::OP_ACK: begin
        // a corrupt acknowledgement never reaches the back end
        keep       = checksum_ok;
        entry.cmd  = gbn_pkg::CMD_ACK;
        entry.data = ack_number;
      end
      gbn_pkg::OP_TICK: begin
        keep      = 1'b1;
        entry.cmd = gbn_pkg::CMD_TICK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (q_count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (q_count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_head   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= entry;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

endmodule

// ===== hdl/gbn_back.sv =====
// Back end of the go-back-N sender: window state, window buffer, pending
// FIFO, retransmission timer and the result register. Depends on gbn_pkg.
module gbn_back (
  input  logic                      clk,
  input  logic                      rst,
  input  gbn_pkg::gbn_cfg_t         cfg,
  input  logic                      q_valid,
  input  gbn_pkg::gbn_entry_t       q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                kind,
  output logic [gbn_pkg::DATA_W-1:0] seq_number,
  output logic [gbn_pkg::DATA_W-1:0] payload_out,
  output logic                      last
);

  localparam int DW     = gbn_pkg::DATA_W;
  localparam int SLOT_W = (gbn_pkg::WINDOW_MAX > 1) ? $clog2(gbn_pkg::WINDOW_MAX) : 1;
  localparam int EFF_W  = $clog2(gbn_pkg::WINDOW_MAX + 1);
  localparam int PTR_W  = (gbn_pkg::PENDING_DEPTH > 1) ? $clog2(gbn_pkg::PENDING_DEPTH) : 1;
  localparam int PCNT_W = $clog2(gbn_pkg::PENDING_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_RETX
  } state_t;

  // base + off where base < WINDOW_MAX and off <= WINDOW_MAX
  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] b, logic [SLOT_W:0] off);
    logic [SLOT_W+1:0] s;
    s = {2'b00, b} + {1'b0, off};
    if (s >= (SLOT_W+2)'(gbn_pkg::WINDOW_MAX)) begin
      s = s - (SLOT_W+2)'(gbn_pkg::WINDOW_MAX);
    end
    return s[SLOT_W-1:0];
  endfunction

  // ptr + cnt where ptr < PENDING_DEPTH and cnt <= PENDING_DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [PCNT_W-1:0] c);
    logic [PCNT_W+1:0] s;
    s = (PCNT_W+2)'(p) + (PCNT_W+2)'(c);
    if (s >= (PCNT_W+2)'(gbn_pkg::PENDING_DEPTH)) begin
      s = s - (PCNT_W+2)'(gbn_pkg::PENDING_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  state_t             state;
  logic [DW-1:0]      window_base;
  logic [DW-1:0]      next_sequence;
  logic [SLOT_W-1:0]  base_slot;
  logic [DW-1:0]      window_buffer [gbn_pkg::WINDOW_MAX];
  logic [DW-1:0]      pending_fifo [gbn_pkg::PENDING_DEPTH];
  logic [PCNT_W-1:0]  pending_count;
  logic [PTR_W-1:0]   pending_read_pointer;
  logic [DW-1:0]      timer_count;
  logic               timer_running;
  logic [SLOT_W:0]    retx_idx;

  logic [DW-1:0]      outs;
  logic [EFF_W-1:0]   eff;
  logic [DW-1:0]      eff_wide;
  logic               room;
  logic               out_free;
  logic [DW-1:0]      adv;
  logic               ack_ok;
  logic [DW:0]        tick_cnt;
  logic [DW-1:0]      limit;
  logic               expire;
  logic               drain_go;
  logic               drain_last;
  logic               retx_last;
  logic [DW-1:0]      pend_head;

  logic               emit;
  logic [1:0]         e_kind;
  logic [DW-1:0]      e_seq;
  logic [DW-1:0]      e_pay;
  logic               e_last;
  logic               do_send;
  logic [DW-1:0]      send_handle;
  logic               do_queue;
  logic               do_unqueue;

  always_comb begin
    if (cfg.window_size == '0) begin
      eff = EFF_W'(1);
    end else if (cfg.window_size > gbn_pkg::WSIZE_W'(gbn_pkg::WINDOW_MAX)) begin
      eff = EFF_W'(gbn_pkg::WINDOW_MAX);
    end else begin
      eff = EFF_W'(cfg.window_size);
    end
  end

  assign outs       = next_sequence - window_base;
  assign eff_wide   = DW'(eff);
  assign room       = outs < eff_wide;
  assign out_free   = !out_valid || !out_stall;
  assign adv        = q_head.data + DW'(1) - window_base;
  assign ack_ok     = (adv != '0) && (adv <= outs);
  assign tick_cnt   = {1'b0, timer_count} + (DW+1)'(1);
  assign limit      = (cfg.timeout_ticks == '0) ? DW'(1) : cfg.timeout_ticks;
  assign expire     = tick_cnt >= {1'b0, limit};
  assign drain_go   = room && (pending_count != '0);
  assign drain_last = ((outs + DW'(1)) >= eff_wide) || (pending_count == PCNT_W'(1));
  assign retx_last  = (DW'(retx_idx) + DW'(1)) == outs;
  assign pend_head  = pending_fifo[pending_read_pointer];
  assign q_pop      = (state == S_IDLE) && q_valid && out_free;

  always_comb begin
    emit        = 1'b0;
    e_kind      = gbn_pkg::KIND_NEW;
    e_seq       = next_sequence;
    e_pay       = q_head.data;
    e_last      = 1'b1;
    do_send     = 1'b0;
    send_handle = q_head.data;
    do_queue    = 1'b0;
    do_unqueue  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_pop && (q_head.cmd == gbn_pkg::CMD_MSG)) begin
          emit = 1'b1;
          if (room) begin
            do_send = 1'b1;
          end else if (pending_count < PCNT_W'(gbn_pkg::PENDING_DEPTH)) begin
            do_queue = 1'b1;
            e_kind   = gbn_pkg::KIND_QUEUED;
            e_seq    = '0;
          end else begin
            e_kind = gbn_pkg::KIND_DROPPED;
            e_seq  = '0;
          end
        end
      end
      S_DRAIN: begin
        if (drain_go && out_free) begin
          emit        = 1'b1;
          do_send     = 1'b1;
          do_unqueue  = 1'b1;
          send_handle = pend_head;
          e_pay       = pend_head;
          e_last      = drain_last;
        end
      end
      S_RETX: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = gbn_pkg::KIND_RETX;
          e_seq  = window_base + DW'(retx_idx);
          e_pay  = window_buffer[slot_add(base_slot, retx_idx)];
          e_last = retx_last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      window_base          <= '0;
      next_sequence        <= '0;
      base_slot            <= '0;
      pending_count        <= '0;
      pending_read_pointer <= '0;
      timer_count          <= '0;
      timer_running        <= 1'b0;
      retx_idx             <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid   <= 1'b1;
        kind        <= e_kind;
        seq_number  <= e_seq;
        payload_out <= e_pay;
        last        <= e_last;
      end

      if (do_send) begin
        window_buffer[slot_add(base_slot, outs[SLOT_W:0])] <= send_handle;
        next_sequence <= next_sequence + DW'(1);
        if (outs == '0) begin
          timer_running <= 1'b1;
          timer_count   <= '0;
        end
      end

      if (do_queue) begin
        pending_fifo[ptr_add(pending_read_pointer, pending_count)] <= q_head.data;
        pending_count <= pending_count + PCNT_W'(1);
      end

      if (do_unqueue) begin
        pending_count <= pending_count - PCNT_W'(1);
        if (pending_read_pointer == PTR_W'(gbn_pkg::PENDING_DEPTH - 1)) begin
          pending_read_pointer <= '0;
        end else begin
          pending_read_pointer <= pending_read_pointer + PTR_W'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_head.cmd)
              gbn_pkg::CMD_ACK: begin
                if (ack_ok) begin
                  window_base   <= window_base + adv;
                  base_slot     <= slot_add(base_slot, adv[SLOT_W:0]);
                  // restart the timer only if packets remain outstanding
                  timer_running <= (outs != adv);
                  timer_count   <= '0;
                  state         <= S_DRAIN;
                end
              end
              gbn_pkg::CMD_TICK: begin
                if (timer_running) begin
                  if (expire) begin
                    timer_count <= '0;
                    if (outs == '0) begin
                      timer_running <= 1'b0;
                    end else begin
                      retx_idx <= '0;
                      state    <= S_RETX;
                    end
                  end else begin
                    timer_count <= tick_cnt[DW-1:0];
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DRAIN: begin
          if (!drain_go || (out_free && drain_last)) begin
            state <= S_IDLE;
          end
        end
        S_RETX: begin
          if (out_free) begin
            retx_idx <= retx_idx + (SLOT_W+1)'(1);
            if (retx_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/go_back_n_sender_unit.sv =====
// Top level of the go-back-N sender: configuration registers on the APB-style
// port, front end (gbn_front) and back end (gbn_back). Depends on gbn_pkg.
//
//  channel  direction  handshake                      payload
//  in       into unit  in_valid / in_stall            opcode, payload_handle,
//                                                     ack_number, checksum_ok
//  out      from unit  out_valid / out_stall          kind, seq_number,
//                                                     payload_out, last
//  cfg      into unit  psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// The back end handles one command at a time through its single result register:
// a message, a dropped acknowledgement or a tick that does not expire gives at
// most one result; a valid acknowledgement then sends queued messages while the
// window has room, and an expiring tick resends every outstanding packet (up to
// the window, eight by default). A two-entry command queue lets the input side
// run ahead. Synchronous reset clears all control state; the window buffer and
// pending FIFO hold no reset value. Stalls on the output hold the back end while
// the front keeps accepting until its queue fills.
module go_back_n_sender_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic [gbn_pkg::DATA_W-1:0] payload_handle,
  input  logic [gbn_pkg::DATA_W-1:0] ack_number,
  input  logic                      checksum_ok,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                kind,
  output logic [gbn_pkg::DATA_W-1:0] seq_number,
  output logic [gbn_pkg::DATA_W-1:0] payload_out,
  output logic                      last
);

  gbn_pkg::gbn_cfg_t   cfg;
  gbn_pkg::gbn_entry_t q_head;
  logic                q_valid;
  logic                q_pop;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      gbn_pkg::REG_WINDOW_SIZE:   prdata = 32'(cfg.window_size);
      gbn_pkg::REG_TIMEOUT_TICKS: prdata = 32'(cfg.timeout_ticks);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size   <= gbn_pkg::WINDOW_SIZE_RST;
      cfg.timeout_ticks <= gbn_pkg::TIMEOUT_TICKS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        gbn_pkg::REG_WINDOW_SIZE:   cfg.window_size   <= pwdata[gbn_pkg::WSIZE_W-1:0];
        gbn_pkg::REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[gbn_pkg::TOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gbn_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .payload_handle (payload_handle),
    .ack_number     (ack_number),
    .checksum_ok    (checksum_ok),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  gbn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .seq_number  (seq_number),
    .payload_out (payload_out),
    .last        (last)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for go_back_n_sender_unit: directed window, timer and
// overflow cases, then random traffic, checked against a behavioural predictor.
// Depends on gbn_pkg and the go_back_n_sender_unit RTL.
module tb_top;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused opcode, block ignores it
  localparam int SETTLE_CYCLES = 32;
  localparam int IDLE_PCT = 24;

  typedef struct {
    logic [1:0]                 kind;
    logic [gbn_pkg::DATA_W-1:0] seq;
    logic [gbn_pkg::DATA_W-1:0] pay;
    logic                       last;
  } outcome_t;

  logic                       clk;
  logic                       rst;
  logic                       psel, penable, pwrite, pready;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata, prdata;
  logic                       in_valid, in_stall;
  logic [1:0]                 opcode;
  logic [gbn_pkg::DATA_W-1:0] payload_handle, ack_number;
  logic                       checksum_ok;
  logic                       out_valid, out_stall;
  logic [1:0]                 kind;
  logic [gbn_pkg::DATA_W-1:0] seq_number, payload_out;
  logic                       last;

  go_back_n_sender_unit dut (.*);

  // predictor state
  logic [gbn_pkg::DATA_W-1:0]  m_base = '0;
  logic [gbn_pkg::DATA_W-1:0]  m_next = '0;
  logic [gbn_pkg::DATA_W-1:0]  m_win_buf [gbn_pkg::WINDOW_MAX];
  logic [gbn_pkg::DATA_W-1:0]  m_pend [gbn_pkg::PENDING_DEPTH];
  int unsigned                 m_pend_cnt = 0;
  int unsigned                 m_pend_rd = 0;
  int unsigned                 m_base_slot = 0;
  logic [gbn_pkg::DATA_W-1:0]  m_tmr = '0;
  bit                          m_tmr_on = 0;
  logic [gbn_pkg::WSIZE_W-1:0] cfg_wsize = gbn_pkg::WINDOW_SIZE_RST;
  logic [gbn_pkg::TOUT_W-1:0]  cfg_tout = gbn_pkg::TIMEOUT_TICKS_RST;

  outcome_t outcome_q[$];
  outcome_t step_out[$];
  int  err_count = 0;
  bit  idle_on = 1;
  int  hold_off_left = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned in_flight();
    logic [gbn_pkg::DATA_W-1:0] d;
    d = m_next - m_base;
    return 32'(d);
  endfunction

  function automatic int unsigned eff_window();
    if (cfg_wsize == 0) return 1;
    if (cfg_wsize > gbn_pkg::WINDOW_MAX) return gbn_pkg::WINDOW_MAX;
    return 32'(cfg_wsize);
  endfunction

  function automatic void launch(input logic [gbn_pkg::DATA_W-1:0] h);
    int unsigned outs;
    outs = in_flight();
    m_win_buf[(m_base_slot + outs) % gbn_pkg::WINDOW_MAX] = h;
    if (outs == 0) begin
      m_tmr_on = 1;
      m_tmr = '0;
    end
    step_out.push_back('{kind: gbn_pkg::KIND_NEW, seq: m_next, pay: h, last: 1'b0});
    m_next = m_next + 16'd1;
  endfunction

  // Work out the results of one accepted transaction and append them.
  function automatic void compute_outcomes(input logic [1:0] op,
                                           input logic [gbn_pkg::DATA_W-1:0] h,
                                           input logic [gbn_pkg::DATA_W-1:0] a,
                                           input logic ok);
    logic [gbn_pkg::DATA_W-1:0] d, s;
    int unsigned adv, lim, cnt, outs;
    outcome_t t;
    step_out.delete();
    if (op == gbn_pkg::OP_MSG) begin
      if (in_flight() < eff_window()) begin
        launch(h);
      end else if (m_pend_cnt < gbn_pkg::PENDING_DEPTH) begin
        m_pend[(m_pend_rd + m_pend_cnt) % gbn_pkg::PENDING_DEPTH] = h;
        m_pend_cnt++;
        step_out.push_back('{kind: gbn_pkg::KIND_QUEUED, seq: '0, pay: h, last: 1'b0});
      end else begin
        step_out.push_back('{kind: gbn_pkg::KIND_DROPPED, seq: '0, pay: h, last: 1'b0});
      end
    end else if (op == gbn_pkg::OP_ACK) begin
      d = a + 16'd1 - m_base;
      adv = 32'(d);
      if (ok && adv >= 1 && adv <= in_flight()) begin
        m_base = m_base + d;
        m_base_slot = (m_base_slot + adv) % gbn_pkg::WINDOW_MAX;
        m_tmr_on = (in_flight() != 0);
        m_tmr = '0;
        while (in_flight() < eff_window() && m_pend_cnt > 0) begin
          s = m_pend[m_pend_rd];
          m_pend_rd = (m_pend_rd + 1) % gbn_pkg::PENDING_DEPTH;
          m_pend_cnt--;
          launch(s);
        end
      end
    end else if (op == gbn_pkg::OP_TICK && m_tmr_on) begin
      lim = (cfg_tout == 0) ? 1 : 32'(cfg_tout);
      cnt = 32'(m_tmr) + 1;
      if (cnt >= lim) begin
        outs = in_flight();
        m_tmr = '0;
        m_tmr_on = (outs != 0);
        for (int i = 0; i < outs; i++) begin
          s = m_base + 16'(i);
          step_out.push_back('{kind: gbn_pkg::KIND_RETX, seq: s,
                               pay: m_win_buf[(m_base_slot + i) % gbn_pkg::WINDOW_MAX],
                               last: 1'b0});
        end
      end else begin
        m_tmr = 16'(cnt);
      end
    end
    for (int i = 0; i < step_out.size(); i++) begin
      t = step_out[i];
      t.last = (i == step_out.size() - 1);
      outcome_q.push_back(t);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d seq=%h pay=%h last=%b",
                             kind, seq_number, payload_out, last));
      end else begin
        want = outcome_q.pop_front();
        if (kind !== want.kind || seq_number !== want.seq || payload_out !== want.pay ||
            last !== want.last)
          flag_error($sformatf("exp kind=%0d seq=%h pay=%h last=%b, got %0d %h %h %b",
                               want.kind, want.seq, want.pay, want.last,
                               kind, seq_number, payload_out, last));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [gbn_pkg::DATA_W-1:0] h,
                           input logic [gbn_pkg::DATA_W-1:0] a, input logic ok);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    payload_handle <= h;
    ack_number     <= a;
    checksum_ok    <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_outcomes(op, h, a, ok);
  endtask

  // Hold the input until every expected result is out, then let the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] v);
    logic [31:0] mask;
    mask = (idx == gbn_pkg::REG_WINDOW_SIZE) ? 32'h7F : 32'hFFFF;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == gbn_pkg::REG_WINDOW_SIZE) cfg_wsize = v[gbn_pkg::WSIZE_W-1:0];
    else cfg_tout = v[gbn_pkg::TOUT_W-1:0];
    // read back straight after the write
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (v & mask))
      flag_error($sformatf("register %0d read %h, wrote %h", idx, prdata, v));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_basic_window();
    write_register(gbn_pkg::REG_WINDOW_SIZE, 32'd2);
    write_register(gbn_pkg::REG_TIMEOUT_TICKS, 32'd0);   // zero timeout acts as one tick
    send_item(gbn_pkg::OP_MSG, 16'h0000, 16'hFFFF, 1'b1);
    send_item(gbn_pkg::OP_MSG, 16'hFFFF, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_MSG, 16'h1234, 16'h0000, 1'b1);  // window full: queued
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(gbn_pkg::OP_ACK, 16'h0000, 16'h0000, 1'b0);  // corrupt
    send_item(gbn_pkg::OP_ACK, 16'hFFFF, 16'h0005, 1'b1);  // beyond outstanding
    send_item(gbn_pkg::OP_ACK, 16'h0000, 16'hFFFF, 1'b1);  // behind the base
    send_item(gbn_pkg::OP_ACK, 16'h0000, 16'h0000, 1'b1);  // advance, drain queue
    send_item(gbn_pkg::OP_ACK, 16'h0000, 16'h0000, 1'b1);  // repeat
    send_item(gbn_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0); // expiry, resend window
    send_item(gbn_pkg::OP_ACK, 16'h0000, 16'h0002, 1'b1);  // all acknowledged
    send_item(gbn_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1); // timer stopped
    wait_idle();
  endtask

  task automatic test_single_window();
    write_register(gbn_pkg::REG_WINDOW_SIZE, 32'd0);     // acts as one
    write_register(gbn_pkg::REG_TIMEOUT_TICKS, 32'd2);
    send_item(gbn_pkg::OP_MSG, 16'hA5A5, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_MSG, 16'h5A5A, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_ACK, 16'h0000, m_base, 1'b1);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b1);
    send_item(gbn_pkg::OP_ACK, 16'h0000, m_base, 1'b1);
    wait_idle();
  endtask

  task automatic test_window_shrink();
    write_register(gbn_pkg::REG_WINDOW_SIZE, 32'd8);
    write_register(gbn_pkg::REG_TIMEOUT_TICKS, 32'd65535);
    repeat (4) send_item(gbn_pkg::OP_MSG, 16'($urandom), 16'($urandom), 1'b1);
    wait_idle();
    write_register(gbn_pkg::REG_WINDOW_SIZE, 32'd2);
    send_item(gbn_pkg::OP_MSG, 16'h0F0F, 16'h0000, 1'b1);   // still over the window: queued
    send_item(gbn_pkg::OP_ACK, 16'h0000, m_base, 1'b1);     // three left, no send
    send_item(gbn_pkg::OP_ACK, 16'h0000, m_next - 16'd1, 1'b1);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_register(gbn_pkg::REG_WINDOW_SIZE, 32'd3);
    hold_off_left = 400;
    // keep offering while results are held: queue fills, then messages drop
    repeat (24) send_item(gbn_pkg::OP_MSG, 16'($urandom), 16'($urandom), 1'b1);
    wait_idle();
    send_item(gbn_pkg::OP_ACK, 16'h0000, m_base + 16'd2, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int ws[5] = '{8, 64, 127, 1, 6};
    int to[5] = '{3, 4, 2, 1, 65535};
    int counted;
    int r;
    logic [1:0] op;
    logic [gbn_pkg::DATA_W-1:0] h, a;
    logic ok;
    for (int p = 0; p < 5; p++) begin
      write_register(gbn_pkg::REG_WINDOW_SIZE, ws[p]);
      write_register(gbn_pkg::REG_TIMEOUT_TICKS, to[p]);
      idle_on = (p != 1);
      counted = 0;
      // the phase without idling runs longest
      while (counted < ((p == 1) ? 18 : 8)) begin
        r = $urandom_range(99);
        h = 16'($urandom);
        a = 16'($urandom);
        ok = 1'b1;
        if (r < 40) begin
          op = gbn_pkg::OP_MSG;
          counted++;
        end else if (r < 65 && in_flight() > 0) begin
          op = gbn_pkg::OP_ACK;
          a = m_base + 16'($urandom_range(0, in_flight() - 1));
          counted++;
        end else if (r < 85) begin
          op = gbn_pkg::OP_TICK;
          counted++;
        end else if (r < 90) begin
          op = gbn_pkg::OP_ACK;
          ok = 1'b0;
        end else if (r < 95) begin
          op = gbn_pkg::OP_ACK;
          ok = 1'($urandom_range(1));
        end else begin
          op = OP_NONE;
          ok = 1'($urandom_range(1));
        end
        send_item(op, h, a, ok);
      end
      wait_idle();
    end
    idle_on = 1;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid <= 1'b0; opcode <= gbn_pkg::OP_MSG; payload_handle <= '0; ack_number <= '0;
    checksum_ok <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_basic_window();
    test_single_window();
    test_window_shrink();
    test_backpressure();
    test_random_traffic();

    for (int k = 0; k < 20000 && outcome_q.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", outcome_q.size()));
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
